[rtl/core/tzsp_pkg.sv]
// ----------------------------------------------------------------------------
// TZSP header parser package
// Shared types and constants for the header parser, its result queue and
// its output stage.
// ----------------------------------------------------------------------------
package tzsp_pkg;

   // Longest message that is parsed; bytes beyond it flag an error.
   localparam int unsigned MaxMessageBytes = 65535;
   localparam int unsigned CountBits       = 16;
   localparam int unsigned HeaderBytes     = 4;

   localparam logic [7:0] TzspVersion = 8'd1;
   localparam logic [7:0] TagPadding  = 8'd0;
   localparam logic [7:0] TagEnd      = 8'd1;

   // Result queue between the parser and the output stage.
   localparam int unsigned QueueDepth   = 2;
   localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
   localparam int unsigned QueueCntBits = $clog2(QueueDepth + 1);

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_SHORT_HEADER = 3'd1,
      ST_BAD_VERSION  = 3'd2,
      ST_SHORT_LIST   = 3'd3,
      ST_SHORT_TAG    = 3'd4,
      ST_TOO_LONG     = 3'd5
   } status_type;

   // What the parser hands over at the end of a message.
   typedef struct packed {
      status_type             status;
      logic [7:0]             message_type;
      logic [15:0]            link_id;
      logic [CountBits-1:0]   payload_start;
      logic [CountBits-1:0]   byte_count;
   } summary_type;

   // Result word as it leaves the block.
   typedef struct packed {
      logic [4:0]  pad;
      logic [15:0] body_length;
      logic [15:0] body_offset;
      logic [15:0] link_id;
      logic [7:0]  message_type;
      logic [2:0]  status;
   } result_type;

endpackage

[rtl/core/tzsp_parse_front.sv]
// ----------------------------------------------------------------------------
// TZSP parser front end
// Walks the header and tag list one byte per cycle unless the queue is full
// and produces a summary record when the last byte of a message is taken.
// ----------------------------------------------------------------------------
module tzsp_parse_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   output logic                 byte_ready,
   input  logic [7:0]           message_byte,
   input  logic                 last_byte,
   input  logic                 queue_full,
   output logic                 summary_push,
   output tzsp_pkg::summary_type summary
);
   import tzsp_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TAG_TYPE,
      PH_TAG_LEN,
      PH_TAG_DATA,
      PH_PAYLOAD
   } phase_type;

   localparam logic [CountBits-1:0] CountMax = CountBits'(MaxMessageBytes);
   localparam logic [CountBits-1:0] CountHdr = CountBits'(HeaderBytes);

   phase_type            phase_ff, phase_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [7:0]           skip_ff, skip_in;
   logic [7:0]           type_ff, type_in;
   logic [15:0]          link_ff, link_in;
   logic [CountBits-1:0] start_ff, start_in;
   status_type           error_ff, error_in;
   status_type           status;
   logic                 take;

   assign byte_ready = !queue_full;
   assign take       = byte_valid && byte_ready;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      skip_in  = skip_ff;
      type_in  = type_ff;
      link_in  = link_ff;
      start_in = start_ff;
      error_in = error_ff;
      if (count_ff >= CountMax) begin
         // Too long: no more parsing, only the error is noted.
         if (error_ff == ST_OK) begin
            error_in = ST_TOO_LONG;
         end
      end else begin
         count_in = count_ff + 1'b1;
         unique case (phase_ff)
            PH_HEADER: begin
               if (count_ff == '0) begin
                  if (message_byte != TzspVersion && error_ff == ST_OK) begin
                     error_in = ST_BAD_VERSION;
                  end
               end else if (count_ff == CountBits'(1)) begin
                  type_in = message_byte;
               end else if (count_ff == CountBits'(2)) begin
                  link_in = {message_byte, 8'd0};
               end else begin
                  link_in  = {link_ff[15:8], message_byte};
                  phase_in = PH_TAG_TYPE;
               end
            end
            PH_TAG_TYPE: begin
               if (message_byte == TagEnd) begin
                  start_in = count_ff + 1'b1;
                  phase_in = PH_PAYLOAD;
               end else if (message_byte != TagPadding) begin
                  phase_in = PH_TAG_LEN;
               end
            end
            PH_TAG_LEN: begin
               skip_in  = message_byte;
               phase_in = (message_byte != 8'd0) ? PH_TAG_DATA : PH_TAG_TYPE;
            end
            PH_TAG_DATA: begin
               skip_in = skip_ff - 1'b1;
               if (skip_in == 8'd0) begin
                  phase_in = PH_TAG_TYPE;
               end
            end
            PH_PAYLOAD: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Final status; header truncation outranks any recorded error.
   always_comb begin
      priority if (count_in < CountHdr) begin
         status = ST_SHORT_HEADER;
      end else if (error_in != ST_OK) begin
         status = error_in;
      end else if (phase_in == PH_TAG_TYPE) begin
         status = ST_SHORT_LIST;
      end else if (phase_in == PH_TAG_LEN || phase_in == PH_TAG_DATA) begin
         status = ST_SHORT_TAG;
      end else begin
         status = ST_OK;
      end
   end

   assign summary_push          = take && last_byte;
   assign summary.status        = status;
   assign summary.message_type  = type_in;
   assign summary.link_id       = link_in;
   assign summary.payload_start = start_in;
   assign summary.byte_count    = count_in;

   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         phase_ff <= PH_HEADER;
         count_ff <= '0;
         skip_ff  <= '0;
         type_ff  <= '0;
         link_ff  <= '0;
         start_ff <= '0;
         error_ff <= ST_OK;
      end else if (take) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         skip_ff  <= skip_in;
         type_ff  <= type_in;
         link_ff  <= link_in;
         start_ff <= start_in;
         error_ff <= error_in;
      end
   end

endmodule

[rtl/core/tzsp_queue.sv]
// ----------------------------------------------------------------------------
// TZSP summary queue
// Short first-in first-out queue that decouples the parser from the output
// stage.
// ----------------------------------------------------------------------------
module tzsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tzsp_pkg::summary_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output tzsp_pkg::summary_type pop_data
);
   import tzsp_pkg::*;

   summary_type             mem_ff [QueueDepth];
   logic [QueuePtrBits-1:0] wr_ptr_ff;
   logic [QueuePtrBits-1:0] rd_ptr_ff;
   logic [QueueCntBits-1:0] fill_ff, fill_in;

   assign full      = (fill_ff == QueueCntBits'(QueueDepth));
   assign not_empty = (fill_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0
                                                                      : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0
                                                                      : rd_ptr_ff + 1'b1;
         end
         fill_ff <= fill_in;
      end
   end

endmodule

[rtl/core/tzsp_result_back.sv]
// ----------------------------------------------------------------------------
// TZSP result stage
// Turns a summary record into the result word and holds it in the output
// register until it is taken.
// ----------------------------------------------------------------------------
module tzsp_result_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  summary_valid,
   input  tzsp_pkg::summary_type summary,
   output logic                  summary_pop,
   output logic                  result_valid,
   input  logic                  result_ready,
   output tzsp_pkg::result_type  result
);
   import tzsp_pkg::*;

   logic       valid_ff;
   result_type result_ff, result_in;
   logic       header_bad;
   logic       all_ok;

   assign summary_pop = summary_valid && (!valid_ff || result_ready);

   // Header fields mean nothing if the header itself is broken, and the
   // payload position is only reported for a clean message.
   assign header_bad = (summary.status == ST_SHORT_HEADER) ||
                       (summary.status == ST_BAD_VERSION);
   assign all_ok     = (summary.status == ST_OK);

   always_comb begin
      result_in.pad          = '0;
      result_in.status       = summary.status;
      result_in.message_type = header_bad ? 8'd0  : summary.message_type;
      result_in.link_id      = header_bad ? 16'd0 : summary.link_id;
      result_in.body_offset  = all_ok ? summary.payload_start : 16'd0;
      result_in.body_length  = all_ok ? (summary.byte_count - summary.payload_start)
                                      : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (summary_pop) begin
         valid_ff <= 1'b1;
      end else if (result_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (summary_pop) begin
         result_ff <= result_in;
      end
   end

   assign result_valid = valid_ff;
   assign result       = result_ff;

endmodule

[rtl/core/tzsp_header_tag_parser.sv]
// ----------------------------------------------------------------------------
// TZSP header and tag parser
// Parses the encapsulation header and tag list of a message streamed one
// byte per word, and reports status and payload position at its end.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle across messages, unless the queue is full.
// The summary enters the queue at the edge that takes the last byte, moves
// to the output register once that is empty or its word is being taken,
// and the result word is valid while it is held there.
// Reset is synchronous and active high; it empties the queue, drops any
// pending result and returns the parser to the start of a message.
// ----------------------------------------------------------------------------
module tzsp_header_tag_parser (
   input  logic        clock,
   input  logic        reset,
   // Input byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] message_byte
   input  logic        req_tlast,   // last_byte
   // Result stream, one word per message.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [2:0] status, [10:3] message_type,
                                    // [26:11] link_id, [42:27] body_offset,
                                    // [58:43] body_length, [63:59] zero
);
   import tzsp_pkg::*;

   summary_type front_summary;
   summary_type queue_summary;
   logic        front_push;
   logic        queue_full;
   logic        queue_not_empty;
   logic        back_pop;
   result_type  back_result;

   // The front end parses each byte as it arrives. It stalls only when the
   // summary queue is full, so bytes keep flowing while a result waits.
   tzsp_parse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_tvalid),
      .byte_ready   (req_tready),
      .message_byte (req_tdata),
      .last_byte    (req_tlast),
      .queue_full   (queue_full),
      .summary_push (front_push),
      .summary      (front_summary)
   );

   // The queue holds finished message summaries between the two halves.
   tzsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_summary),
      .full      (queue_full),
      .pop       (back_pop),
      .not_empty (queue_not_empty),
      .pop_data  (queue_summary)
   );

   // The back end masks the fields that have no meaning for the status,
   // computes the payload length and holds the result word.
   tzsp_result_back u_back (
      .clock         (clock),
      .reset         (reset),
      .summary_valid (queue_not_empty),
      .summary       (queue_summary),
      .summary_pop   (back_pop),
      .result_valid  (rsp_tvalid),
      .result_ready  (rsp_tready),
      .result        (back_result)
   );

   assign rsp_tdata = back_result;

endmodule

[rtl/core/tzsp_checker.sv]
// ----------------------------------------------------------------------------
// TZSP parser port checker
// Watches the ports of the parser for result words that break its rules.
// ----------------------------------------------------------------------------
module tzsp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tready,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata
);
   import tzsp_pkg::*;

   // A stalled result word stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // After reset nothing is pending and the input side is open.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   // Status codes above too long are never produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd6 && rsp_tdata[2:0] != 3'd7)
      else $error("status out of range");

   // Payload position is only given for a clean message.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[58:27] == 32'd0)
      else $error("payload fields set on failed message");

   // A broken header leaves message type and link id zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == ST_SHORT_HEADER ||
                     rsp_tdata[2:0] == ST_BAD_VERSION) |-> rsp_tdata[26:3] == 24'd0)
      else $error("header fields set on broken header");

endmodule

bind tzsp_header_tag_parser tzsp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[verif/tzsp_parse_checker.sv]
// ----------------------------------------------------------------------------
// TZSP parser result checker
// Watches the byte stream and the result stream of the header and tag
// parser, works out the result of every message from the bytes taken, and
// compares each result word field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module tzsp_parse_checker
   import tzsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] message_byte
   input  logic        req_tlast,   // last_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [2:0] status, [10:3] message_type,
                                    // [26:11] link_id, [42:27] body_offset,
                                    // [58:43] body_length, [63:59] zero
   output int unsigned mismatches,
   output int unsigned results_pending,
   output int unsigned results_checked
);

   typedef enum logic [2:0] {
      AT_HEADER,
      AT_TAG_TYPE,
      AT_TAG_LEN,
      AT_TAG_DATA,
      IN_PAYLOAD
   } walk_type;

   // Running view of the message now arriving.
   logic [15:0] bytes_seen;
   walk_type    walk;
   logic [7:0]  skip_left;
   logic [7:0]  seen_type;
   logic [15:0] seen_link;
   logic [15:0] data_start;
   status_type  first_error;

   // Results of finished messages that have not left the block yet.
   result_type  results_due[$];

   task automatic clear_message();
      bytes_seen  = '0;
      walk        = AT_HEADER;
      skip_left   = '0;
      seen_type   = '0;
      seen_link   = '0;
      data_start  = '0;
      first_error = ST_OK;
   endtask

   task automatic walk_byte(input logic [15:0] idx, input logic [7:0] b);
      case (walk)
         AT_HEADER: begin
            case (idx)
               16'd0: begin
                  if (b != TzspVersion && first_error == ST_OK)
                     first_error = ST_BAD_VERSION;
               end
               16'd1: seen_type = b;
               16'd2: seen_link = {b, 8'h00};
               default: begin
                  seen_link[7:0] = b;
                  walk = AT_TAG_TYPE;
               end
            endcase
         end
         AT_TAG_TYPE: begin
            if (b == TagEnd) begin
               data_start = idx + 16'd1;
               walk = IN_PAYLOAD;
            end else if (b != TagPadding) begin
               walk = AT_TAG_LEN;
            end
         end
         AT_TAG_LEN: begin
            skip_left = b;
            walk = (b != 8'd0) ? AT_TAG_DATA : AT_TAG_TYPE;
         end
         AT_TAG_DATA: begin
            skip_left = skip_left - 8'd1;
            if (skip_left == 8'd0)
               walk = AT_TAG_TYPE;
         end
         default: ;
      endcase
   endtask

   // The message has ended: its status follows the precedence of errors,
   // and fields without meaning for that status are zero.
   task automatic close_message();
      status_type st;
      result_type want;
      if (bytes_seen < HeaderBytes)
         st = ST_SHORT_HEADER;
      else if (first_error != ST_OK)
         st = first_error;
      else if (walk == AT_TAG_TYPE)
         st = ST_SHORT_LIST;
      else if (walk == AT_TAG_LEN || walk == AT_TAG_DATA)
         st = ST_SHORT_TAG;
      else
         st = ST_OK;
      want = '0;
      want.status = st;
      if (st != ST_SHORT_HEADER && st != ST_BAD_VERSION) begin
         want.message_type = seen_type;
         want.link_id      = seen_link;
      end
      if (st == ST_OK) begin
         want.body_offset = data_start;
         want.body_length = bytes_seen - data_start;
      end
      results_due.push_back(want);
      clear_message();
   endtask

   task automatic take_byte(input logic [7:0] b, input logic last);
      // Past the size bound the bytes are only flagged, never parsed.
      if (bytes_seen >= MaxMessageBytes) begin
         if (first_error == ST_OK)
            first_error = ST_TOO_LONG;
      end else begin
         walk_byte(bytes_seen, b);
         bytes_seen = bytes_seen + 16'd1;
      end
      if (last)
         close_message();
   endtask

   task automatic note_failure();
      mismatches = mismatches + 1;
   endtask

   task automatic compare_result(input result_type got);
      result_type want;
      if (results_due.size() == 0) begin
         if (mismatches < 10)
            $display("result word %h arrived with no message outstanding", got);
         note_failure();
      end else begin
         want = results_due.pop_front();
         results_checked = results_checked + 1;
         if (got.status !== want.status || got.message_type !== want.message_type ||
             got.link_id !== want.link_id ||
             got.body_offset !== want.body_offset ||
             got.body_length !== want.body_length || got.pad !== want.pad) begin
            if (mismatches < 10)
               $display({"result %0d: expected status %0d type %h link %h offset %0d ",
                         "length %0d pad %h, got status %0d type %h link %h offset %0d ",
                         "length %0d pad %h"},
                        results_checked, want.status, want.message_type, want.link_id,
                        want.body_offset, want.body_length, want.pad,
                        got.status, got.message_type, got.link_id,
                        got.body_offset, got.body_length, got.pad);
            note_failure();
         end
      end
   endtask

   initial begin
      mismatches      = 0;
      results_pending = 0;
      results_checked = 0;
      clear_message();
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_message();
         results_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            compare_result(result_type'(rsp_tdata));
         if (req_tvalid && req_tready)
            take_byte(req_tdata, req_tlast);
      end
      results_pending = results_due.size();
   end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// TZSP header and tag parser testbench
// Streams directed and random messages into the parser, stalls the result
// side at random and once for a long stretch, and lets the checker compare
// every result word against its own prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import tzsp_pkg::*;

   // The limit leaves a wide margin over a correct run, even with the longest
   // gaps and stalls.
   localparam int unsigned CycleLimit      = 500_000;
   localparam int unsigned LongHoldCycles  = 400;
   localparam int unsigned RandomBytesGoal = 1050;
   localparam int unsigned RandomMsgsGoal  = 30;
   localparam int unsigned HoldAtMessage   = 25;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] message_byte
   logic        req_tlast;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;    // [2:0] status, [10:3] message_type,
                              // [26:11] link_id, [42:27] body_offset,
                              // [58:43] body_length, [63:59] zero

   int unsigned mismatches;
   int unsigned results_pending;
   int unsigned results_checked;
   int unsigned cycle_count;
   int unsigned messages_sent;
   int unsigned bytes_sent;
   int unsigned random_messages;
   int unsigned random_bytes;

   // Idling is switched off for some stretches of random traffic so that
   // words follow back to back; both sides idle at random the rest of the time.
   bit          idles_on;
   // The stimulus asks once for a long hold-off on the result side; the
   // ready process serves it and reports that it is done.
   bit          hold_request;
   bit          hold_done;
   int unsigned ready_left;
   int unsigned stall_left;

   // Bytes of the message being built, sent front to back.
   logic [7:0]  msg_bytes[$];

   tzsp_header_tag_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tzsp_parse_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatches      (mismatches),
      .results_pending (results_pending),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Gap length in cycles: none while idling is off, else mostly none, often a few, sometimes a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idles_on)
         return 0;
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic push_random(input int unsigned count);
      repeat (count) msg_bytes.push_back(8'($urandom));
   endtask

   task automatic push_header(input logic [7:0] version, input logic [7:0] mtype,
                              input logic [15:0] link);
      msg_bytes.push_back(version);
      msg_bytes.push_back(mtype);
      msg_bytes.push_back(link[15:8]);
      msg_bytes.push_back(link[7:0]);
   endtask

   // A tag that carries data: type byte, length byte, then the data.
   task automatic push_tag(input logic [7:0] kind, input int unsigned len);
      msg_bytes.push_back(kind);
      msg_bytes.push_back(8'(len));
      push_random(len);
   endtask

   // Sends the built message one word per handshake, last word marked.
   // Inputs change only at the falling edge, and each falling edge sees at
   // most one assignment of req_tvalid.
   task automatic send_message();
      int unsigned gap;
      foreach (msg_bytes[i]) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_tvalid = 1'b1;
         req_tdata  = msg_bytes[i];
         req_tlast  = (i == msg_bytes.size() - 1);
         do @(posedge clock); while (!req_tready);
         @(negedge clock);
         bytes_sent = bytes_sent + 1;
      end
      msg_bytes.delete();
      messages_sent = messages_sent + 1;
   endtask

   // Random traffic: mostly well-formed messages with random content, some
   // cut short at a random byte, and some plain noise.
   task automatic build_random_message();
      int unsigned kind;
      int unsigned cut;
      logic [7:0]  version;
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         push_random($urandom_range(1, 12));
      end else begin
         version = ($urandom_range(0, 19) == 0) ? 8'($urandom) : TzspVersion;
         push_header(version, 8'($urandom), 16'($urandom));
         repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 9) < 3)
               msg_bytes.push_back(TagPadding);
            else
               push_tag(8'($urandom_range(2, 255)),
                        ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 6));
         end
         if ($urandom_range(0, 9) != 0) begin
            msg_bytes.push_back(TagEnd);
            push_random($urandom_range(0, 8));
         end
         if (kind < 30) begin
            cut = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
         end
      end
   endtask

   // Result side: runs of ready words broken by gaps of random length, and
   // once a long hold-off during which the block fills and stalls its input.
   initial begin
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      ready_left = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_tready = 1'b0;
            repeat (LongHoldCycles) @(negedge clock);
            hold_done = 1'b1;
         end else if (!idles_on) begin
            rsp_tready = 1'b1;
         end else if (ready_left > 0) begin
            rsp_tready = 1'b1;
            ready_left = ready_left - 1;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_tready = 1'b1;
            ready_left = $urandom_range(0, 30);
            stall_left = pick_gap();
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
      end
      $display("[tzsp_header_tag_parser] ERROR");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tlast       = 1'b0;
      idles_on        = 1'b1;
      hold_request    = 1'b0;
      messages_sent   = 0;
      bytes_sent      = 0;
      random_messages = 0;
      random_bytes    = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Shortest good message: header and end tag, empty payload.
      push_header(TzspVersion, 8'h00, 16'h0000);
      msg_bytes.push_back(TagEnd);
      send_message();
      // Padding, a data tag and a payload; type and link at their top values.
      push_header(TzspVersion, 8'hff, 16'hffff);
      msg_bytes.push_back(TagPadding);
      msg_bytes.push_back(TagPadding);
      push_tag(8'h02, 3);
      msg_bytes.push_back(TagEnd);
      push_random(5);
      send_message();
      // A tag with zero length, a tag of the highest type, a full 255-byte tag.
      push_header(TzspVersion, 8'h12, 16'h8001);
      push_tag(8'h05, 0);
      push_tag(8'hff, 1);
      push_tag(8'h80, 255);
      msg_bytes.push_back(TagEnd);
      push_random(2);
      send_message();
      // Short header: one byte with a wrong version still reads as short.
      msg_bytes.push_back(8'hff);
      send_message();
      push_header(8'h00, 8'h34, 16'h0);
      void'(msg_bytes.pop_back());
      send_message();
      push_header(TzspVersion, 8'h34, 16'h0);
      void'(msg_bytes.pop_back());
      send_message();
      // Bad version with a complete header, and with a tag list after it.
      push_header(8'h00, 8'h55, 16'h1234);
      send_message();
      push_header(8'h02, 8'h56, 16'habcd);
      push_tag(8'h07, 2);
      msg_bytes.push_back(TagEnd);
      send_message();
      // Tag list ended early: after the header, after padding only.
      push_header(TzspVersion, 8'h01, 16'h0102);
      send_message();
      push_header(TzspVersion, 8'h02, 16'h0304);
      msg_bytes.push_back(TagPadding);
      msg_bytes.push_back(TagPadding);
      send_message();
      // Short tag: after the type byte, after the length byte, inside data.
      push_header(TzspVersion, 8'h03, 16'h0506);
      msg_bytes.push_back(8'h09);
      send_message();
      push_header(TzspVersion, 8'h04, 16'h0708);
      msg_bytes.push_back(8'h09);
      msg_bytes.push_back(8'h04);
      send_message();
      push_header(TzspVersion, 8'h05, 16'h090a);
      push_tag(8'h09, 4);
      void'(msg_bytes.pop_back());
      send_message();
      // Payload bytes that look like tags are not inspected.
      push_header(TzspVersion, 8'h06, 16'h0b0c);
      msg_bytes.push_back(TagEnd);
      msg_bytes.push_back(8'h09);
      msg_bytes.push_back(8'hff);
      send_message();

      // Random traffic; a long result-side hold-off is requested at the start
      // of a stretch without idling, so the input keeps pushing into it.
      while (random_bytes < RandomBytesGoal || random_messages < RandomMsgsGoal) begin
         if (random_messages == HoldAtMessage)
            hold_request = 1'b1;
         // A stretch without idling now and then.
         idles_on = (random_messages % 25) >= 5;
         build_random_message();
         random_bytes = random_bytes + msg_bytes.size();
         send_message();
         random_messages = random_messages + 1;
      end
      idles_on   = 1'b1;
      req_tvalid = 1'b0;

      // Drain, then keep watching for any stray result word.
      while (results_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Sent %0d messages, %0d bytes: directed header, tag and truncation cases",
               messages_sent, bytes_sent);
      $display("and %0d random messages; %0d results checked, %0d mismatched.",
               random_messages, results_checked, mismatches);
      if (mismatches == 0)
         $display("[tzsp_header_tag_parser] OK");
      else
         $display("[tzsp_header_tag_parser] ERROR");
      $finish;
   end

endmodule

[files.f]
rtl/core/tzsp_pkg.sv
rtl/core/tzsp_parse_front.sv
rtl/core/tzsp_queue.sv
rtl/core/tzsp_result_back.sv
rtl/core/tzsp_header_tag_parser.sv
rtl/core/tzsp_checker.sv
verif/tzsp_parse_checker.sv
verif/tb_top.sv
